// ===== hw/rtl/tcgr_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcgr_pkg
// Shared types, codes and constants of the text console glyph renderer.
// ----------------------------------------------------------------------------
package tcgr_pkg;

    localparam int MAX_GLYPH_SIDE = 8;
    localparam int SIDE_W         = $clog2(MAX_GLYPH_SIDE + 1);
    localparam int CNT_W          = (MAX_GLYPH_SIDE > 1) ? $clog2(MAX_GLYPH_SIDE) : 1;

    localparam logic [20:0] CODE_BACKSPACE = 21'd8;
    localparam logic [20:0] CODE_TAB       = 21'd9;
    localparam logic [20:0] CODE_NEWLINE   = 21'd10;
    localparam logic [20:0] CODE_RETURN    = 21'd13;
    localparam logic [9:0]  TAB_STEP       = 10'd4;
    localparam logic [9:0]  MAX_COUNT      = 10'd512;

    localparam logic [2:0] REG_FB_BASE     = 3'd0;
    localparam logic [2:0] REG_PITCH       = 3'd1;
    localparam logic [2:0] REG_GLYPH_W     = 3'd2;
    localparam logic [2:0] REG_GLYPH_H     = 3'd3;
    localparam logic [2:0] REG_COLUMNS     = 3'd4;
    localparam logic [2:0] REG_ROWS        = 3'd5;
    localparam logic [2:0] REG_FORE        = 3'd6;
    localparam logic [2:0] REG_BACK        = 3'd7;

    typedef struct packed {
        logic [20:0] char_code;
        logic [63:0] glyph_bits;
        logic        glyph_present;
    } in_beat_t;

    typedef struct packed {
        logic        write_enable;
        logic [31:0] pixel_address;
        logic [31:0] pixel_value;
        logic        scroll_after;
        logic        last_result;
    } out_beat_t;

    typedef struct packed {
        logic load;
        logic decode;
        logic mul1;
        logic mul2;
        logic emit_pixel;
        logic emit_empty;
    } tcgr_cmd_t;

    typedef struct packed {
        logic paint;
        logic slot_free;
        logic last_pixel;
    } tcgr_status_t;

endpackage

// ===== hw/rtl/tcgr_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcgr_ctrl
// Sequencer: take a beat, decode it, set up the cell address, then issue
// pixel writes or a single empty result.
// ----------------------------------------------------------------------------
module tcgr_ctrl
    import tcgr_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    output logic         in_ready,
    input  tcgr_status_t stat,
    output tcgr_cmd_t    cmd
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_DECODE = 3'd1;
    localparam logic [2:0] ST_MUL1   = 3'd2;
    localparam logic [2:0] ST_MUL2   = 3'd3;
    localparam logic [2:0] ST_PAINT  = 3'd4;
    localparam logic [2:0] ST_EMPTY  = 3'd5;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    assign in_ready = (state_reg == ST_IDLE);

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                cmd.decode = 1'b1;
                state_next = ST_MUL1;
            end
            ST_MUL1:
            begin
                if (stat.paint)
                begin
                    cmd.mul1   = 1'b1;
                    state_next = ST_MUL2;
                end
                else
                begin
                    state_next = ST_EMPTY;
                end
            end
            ST_MUL2:
            begin
                cmd.mul2   = 1'b1;
                state_next = ST_PAINT;
            end
            ST_PAINT:
            begin
                if (stat.slot_free)
                begin
                    cmd.emit_pixel = 1'b1;
                    if (stat.last_pixel)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_EMPTY:
            begin
                if (stat.slot_free)
                begin
                    cmd.emit_empty = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== hw/rtl/tcgr_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcgr_datapath
// Configuration registers, text cursor, cell address arithmetic, pixel
// counters and the output register.
// ----------------------------------------------------------------------------
module tcgr_datapath
    import tcgr_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_we,
    input  logic [2:0]   cfg_index,
    input  logic [31:0]  cfg_data,
    input  in_beat_t     in_data,
    input  tcgr_cmd_t    cmd,
    output tcgr_status_t stat,
    output logic         out_valid,
    input  logic         out_ready,
    output out_beat_t    out_data
);

    logic [31:0] fb_base_reg;
    logic [12:0] pitch_reg;
    logic [3:0]  glyph_w_reg;
    logic [3:0]  glyph_h_reg;
    logic [9:0]  columns_reg;
    logic [9:0]  rows_reg;
    logic [31:0] fore_reg;
    logic [31:0] back_reg;

    logic [8:0]  cur_row_reg;
    logic [8:0]  cur_col_reg;
    logic [8:0]  cur_row_next;
    logic [8:0]  cur_col_next;

    in_beat_t    beat_reg;
    logic        paint_reg;
    logic        paint_next;
    logic        scroll_reg;
    logic        scroll_next;
    logic [8:0]  paint_row_reg;
    logic [8:0]  paint_col_reg;
    logic [8:0]  paint_col_next;

    logic [21:0] row_pitch_reg;
    logic [12:0] col_off_reg;
    logic [31:0] line_addr_reg;
    logic [CNT_W-1:0] x_reg;
    logic [CNT_W-1:0] y_reg;

    logic        out_valid_reg;
    out_beat_t   out_data_reg;

    logic [SIDE_W-1:0] gw_eff;
    logic [SIDE_W-1:0] gh_eff;
    logic [9:0]  cols_eff;
    logic [9:0]  rows_eff;
    logic [9:0]  row_p1;
    logic        nl_wrap;
    logic [8:0]  nl_row;
    logic [9:0]  step;
    logic [9:0]  col_sum;
    logic        col_wrap;
    logic [9:0]  col_adv;
    logic        size_ok;
    logic [25:0] row_off;
    logic [7:0]  glyph_line;
    logic        pixel_set;
    logic        last_x;
    logic        last_y;

    assign gw_eff = (glyph_w_reg > 4'(MAX_GLYPH_SIDE)) ? SIDE_W'(MAX_GLYPH_SIDE)
                                                       : SIDE_W'(glyph_w_reg);
    assign gh_eff = (glyph_h_reg > 4'(MAX_GLYPH_SIDE)) ? SIDE_W'(MAX_GLYPH_SIDE)
                                                       : SIDE_W'(glyph_h_reg);
    assign size_ok = (gw_eff != '0) && (gh_eff != '0);

    assign cols_eff = (columns_reg == 10'd0) ? 10'd1 :
                      (columns_reg > MAX_COUNT) ? MAX_COUNT : columns_reg;
    assign rows_eff = (rows_reg == 10'd0) ? 10'd1 :
                      (rows_reg > MAX_COUNT) ? MAX_COUNT : rows_reg;

    assign row_p1  = {1'b0, cur_row_reg} + 10'd1;
    assign nl_wrap = (row_p1 >= rows_eff);
    assign nl_row  = nl_wrap ? 9'(rows_eff - 10'd1) : row_p1[8:0];

    assign step     = (beat_reg.char_code == CODE_TAB) ? TAB_STEP : 10'd1;
    assign col_sum  = {1'b0, cur_col_reg} + step;
    assign col_wrap = (col_sum >= cols_eff);
    assign col_adv  = col_wrap ? (col_sum - cols_eff) : col_sum;

    always_comb
    begin
        cur_row_next   = cur_row_reg;
        cur_col_next   = cur_col_reg;
        paint_next     = 1'b0;
        scroll_next    = 1'b0;
        paint_col_next = cur_col_reg;
        case (beat_reg.char_code)
            CODE_NEWLINE:
            begin
                cur_row_next = nl_row;
                cur_col_next = 9'd0;
                scroll_next  = nl_wrap;
            end
            CODE_RETURN:
            begin
                cur_col_next = 9'd0;
            end
            CODE_TAB:
            begin
                cur_col_next = col_adv[8:0];
                if (col_wrap)
                begin
                    cur_row_next = nl_row;
                    scroll_next  = nl_wrap;
                end
            end
            CODE_BACKSPACE:
            begin
                if (cur_col_reg != 9'd0)
                begin
                    cur_col_next   = cur_col_reg - 9'd1;
                    paint_col_next = cur_col_reg - 9'd1;
                    paint_next     = beat_reg.glyph_present && size_ok;
                end
            end
            default:
            begin
                if (beat_reg.glyph_present)
                begin
                    paint_next   = size_ok;
                    cur_col_next = col_adv[8:0];
                    if (col_wrap)
                    begin
                        cur_row_next = nl_row;
                        scroll_next  = nl_wrap;
                    end
                end
            end
        endcase
    end

    assign row_off    = row_pitch_reg * gh_eff;
    assign glyph_line = beat_reg.glyph_bits[{y_reg, 3'b000} +: 8];
    assign pixel_set  = glyph_line[3'd7 - 3'(x_reg)];
    assign last_x     = (SIDE_W'(x_reg) == gw_eff - SIDE_W'(1));
    assign last_y     = (SIDE_W'(y_reg) == gh_eff - SIDE_W'(1));

    assign stat.paint      = paint_reg;
    assign stat.slot_free  = !out_valid_reg || out_ready;
    assign stat.last_pixel = last_x && last_y;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fb_base_reg <= 32'd0;
            pitch_reg   <= 13'd640;
            glyph_w_reg <= 4'd8;
            glyph_h_reg <= 4'd8;
            columns_reg <= 10'd80;
            rows_reg    <= 10'd60;
            fore_reg    <= 32'd0;
            back_reg    <= 32'h00FF_FFFF;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_FB_BASE: fb_base_reg <= cfg_data;
                REG_PITCH:   pitch_reg   <= cfg_data[12:0];
                REG_GLYPH_W: glyph_w_reg <= cfg_data[3:0];
                REG_GLYPH_H: glyph_h_reg <= cfg_data[3:0];
                REG_COLUMNS: columns_reg <= cfg_data[9:0];
                REG_ROWS:    rows_reg    <= cfg_data[9:0];
                REG_FORE:    fore_reg    <= cfg_data;
                REG_BACK:    back_reg    <= cfg_data;
                default:     fb_base_reg <= fb_base_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_row_reg   <= 9'd0;
            cur_col_reg   <= 9'd0;
            paint_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.decode)
            begin
                cur_row_reg <= cur_row_next;
                cur_col_reg <= cur_col_next;
                paint_reg   <= paint_next;
            end
            if (cmd.emit_pixel || cmd.emit_empty)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            beat_reg <= in_data;
        end
        if (cmd.decode)
        begin
            scroll_reg    <= scroll_next;
            paint_row_reg <= cur_row_reg;
            paint_col_reg <= paint_col_next;
        end
        if (cmd.mul1)
        begin
            row_pitch_reg <= paint_row_reg * pitch_reg;
            col_off_reg   <= gw_eff * paint_col_reg;
            x_reg         <= '0;
            y_reg         <= '0;
        end
        if (cmd.mul2)
        begin
            line_addr_reg <= fb_base_reg + 32'(row_off) + 32'(col_off_reg);
        end
        if (cmd.emit_pixel)
        begin
            out_data_reg.write_enable  <= 1'b1;
            out_data_reg.pixel_address <= line_addr_reg + 32'(x_reg);
            out_data_reg.pixel_value   <= pixel_set ? fore_reg : back_reg;
            out_data_reg.scroll_after  <= stat.last_pixel && scroll_reg;
            out_data_reg.last_result   <= stat.last_pixel;
            if (last_x)
            begin
                x_reg         <= '0;
                y_reg         <= y_reg + CNT_W'(1);
                line_addr_reg <= line_addr_reg + 32'(pitch_reg);
            end
            else
            begin
                x_reg <= x_reg + CNT_W'(1);
            end
        end
        else if (cmd.emit_empty)
        begin
            out_data_reg.write_enable  <= 1'b0;
            out_data_reg.pixel_address <= 32'd0;
            out_data_reg.pixel_value   <= 32'd0;
            out_data_reg.scroll_after  <= scroll_reg;
            out_data_reg.last_result   <= 1'b1;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

// ===== hw/rtl/text_console_glyph_renderer_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_console_glyph_renderer_core
// Text console renderer: one character beat in, framebuffer pixel writes out.
// ----------------------------------------------------------------------------
// Sequence: a painted glyph passes the states DECODE, MUL1 and MUL2 before its
//   first pixel write is registered; an unpainted item gets its single result from EMPTY.
// Throughput: a painted glyph gives glyph_width * glyph_height pixel writes, one
//   per cycle out of the output register while out_ready holds; a new input
//   beat is taken only after the last result of the previous item is issued.
// Reset: clears the cursor to row 0, column 0 and loads the register defaults.
// ----------------------------------------------------------------------------
module text_console_glyph_renderer_core
    import tcgr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  in_beat_t    in_data,
    output logic        out_valid,
    input  logic        out_ready,
    output out_beat_t   out_data
);

    tcgr_cmd_t    cmd;
    tcgr_status_t stat;

    tcgr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    tcgr_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_data   (in_data),
        .cmd       (cmd),
        .stat      (stat),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input beat taken while an item is in flight");

    a_scroll_on_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.scroll_after |-> out_data.last_result)
        else $error("scroll flagged before the last beat of an item");

    a_inner_writes: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.last_result |-> out_data.write_enable)
        else $error("non-final beat without a pixel write");

    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.write_enable |->
            (out_data.pixel_address == 32'd0) && (out_data.pixel_value == 32'd0))
        else $error("empty beat carries address or value");

endmodule

// ===== sim/tb_text_console_glyph_renderer_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_text_console_glyph_renderer_core
// Self-checking bench for the text console glyph renderer. A scripted table of
// characters and register writes covers reset values, control codes, glyph
// extremes, size clamping and cursor wrap/scroll; random characters follow
// under several register settings and handshake idling patterns. Every output
// beat is compared field by field with a scripted beat or an in-bench cursor and paint model.
// ----------------------------------------------------------------------------
module tb_text_console_glyph_renderer_core;
    import tcgr_pkg::*;

    localparam int unsigned SETTLE_CYCLES = 12;
    localparam int unsigned HOLD_CYCLES   = 300;
    localparam int unsigned RAND_PHASES   = 6;
    localparam int unsigned PHASE_CHARS   = 25;

    localparam out_beat_t NO_PIXEL        = '{1'b0, 32'd0, 32'd0, 1'b0, 1'b1};
    localparam out_beat_t NO_PIXEL_SCROLL = '{1'b0, 32'd0, 32'd0, 1'b1, 1'b1};

    typedef struct {
        bit          is_reg;
        logic [2:0]  index;
        logic [31:0] value;
        in_beat_t    beat;
        bit          typed;
        out_beat_t   want;
    } script_row_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [2:0]  cfg_index;
    logic [31:0] cfg_data;
    logic        in_valid;
    logic        in_ready;
    in_beat_t    in_data;
    logic        out_valid;
    logic        out_ready;
    out_beat_t   out_data;

    // register shadows and cursor
    logic [31:0] r_base;
    logic [12:0] r_pitch;
    logic [3:0]  r_gw;
    logic [3:0]  r_gh;
    logic [9:0]  r_cols;
    logic [9:0]  r_rows;
    logic [31:0] r_fore;
    logic [31:0] r_back;
    logic [8:0]  cur_row;
    logic [8:0]  cur_col;

    out_beat_t   pending_pixels[$];
    out_beat_t   char_writes[$];
    script_row_t script[$];

    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;
    int unsigned hold_requests = 0;
    int unsigned holds_done    = 0;
    int unsigned hold_left     = 0;
    int unsigned mismatches    = 0;
    int unsigned beats_checked = 0;
    int unsigned chars_sent    = 0;
    int unsigned settings_used = 0;
    int unsigned leftover      = 0;

    text_console_glyph_renderer_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    function automatic int unsigned count_limit(input logic [9:0] v);
        if (v == 10'd0)
            return 1;
        if (v > MAX_COUNT)
            return 512;
        return v;
    endfunction

    function automatic int unsigned side_limit(input logic [3:0] v);
        return (v > MAX_GLYPH_SIDE) ? MAX_GLYPH_SIDE : v;
    endfunction

    function automatic bit next_row();
        int unsigned rows;
        rows = count_limit(r_rows);
        if (32'(cur_row) + 1 >= rows)
        begin
            cur_row = 9'(rows - 1);
            return 1'b1;
        end
        cur_row = cur_row + 9'd1;
        return 1'b0;
    endfunction

    function automatic bit advance_cols(input int unsigned step);
        int unsigned cols;
        int unsigned c;
        bit          scroll;
        cols   = count_limit(r_cols);
        c      = 32'(cur_col) + step;
        scroll = 1'b0;
        if (c >= cols)
        begin
            c      = c - cols;
            scroll = next_row();
        end
        cur_col = 9'(c);
        return scroll;
    endfunction

    function automatic void paint_cell(input logic [63:0] bits, input logic [8:0] row,
                                       input logic [8:0] col);
        int unsigned gw;
        int unsigned gh;
        int unsigned i;
        int unsigned j;
        logic [31:0] start;
        logic [31:0] line_addr;
        logic [7:0]  line;
        out_beat_t   px;
        gw    = side_limit(r_gw);
        gh    = side_limit(r_gh);
        start = r_base + 32'(row) * 32'(r_pitch) * gh + gw * 32'(col);
        for (i = 0; i < gh; i++)
        begin
            line      = bits[8*i +: 8];
            line_addr = start + i * 32'(r_pitch);
            for (j = 0; j < gw; j++)
            begin
                px.write_enable  = 1'b1;
                px.pixel_address = line_addr + j;
                px.pixel_value   = line[7-j] ? r_fore : r_back;
                px.scroll_after  = 1'b0;
                px.last_result   = 1'b0;
                char_writes.push_back(px);
            end
        end
    endfunction

    function automatic void predict_glyph_writes(input in_beat_t b);
        bit        scroll;
        out_beat_t tail;
        char_writes.delete();
        scroll = 1'b0;
        case (b.char_code)
            CODE_NEWLINE:
            begin
                scroll  = next_row();
                cur_col = '0;
            end
            CODE_RETURN:
                cur_col = '0;
            CODE_TAB:
                scroll = advance_cols(32'(TAB_STEP));
            CODE_BACKSPACE:
            begin
                if (cur_col != 9'd0)
                begin
                    cur_col = cur_col - 9'd1;
                    if (b.glyph_present)
                        paint_cell(b.glyph_bits, cur_row, cur_col);
                end
            end
            default:
            begin
                if (b.glyph_present)
                begin
                    paint_cell(b.glyph_bits, cur_row, cur_col);
                    scroll = advance_cols(1);
                end
            end
        endcase
        if (char_writes.size() == 0)
            tail = NO_PIXEL;
        else
            tail = char_writes.pop_back();
        tail.scroll_after = scroll;
        tail.last_result  = 1'b1;
        char_writes.push_back(tail);
    endfunction

    function automatic void apply_reg(input logic [2:0] idx, input logic [31:0] val);
        case (idx)
            REG_FB_BASE: r_base  = val;
            REG_PITCH:   r_pitch = val[12:0];
            REG_GLYPH_W: r_gw    = val[3:0];
            REG_GLYPH_H: r_gh    = val[3:0];
            REG_COLUMNS: r_cols  = val[9:0];
            REG_ROWS:    r_rows  = val[9:0];
            REG_FORE:    r_fore  = val;
            REG_BACK:    r_back  = val;
            default:     ;
        endcase
    endfunction

    function automatic in_beat_t make_char(input logic [20:0] code, input logic [63:0] bits,
                                           input logic present);
        in_beat_t b;
        b.char_code     = code;
        b.glyph_bits    = bits;
        b.glyph_present = present;
        return b;
    endfunction

    function automatic void script_reg(input logic [2:0] idx, input logic [31:0] val);
        script_row_t r;
        r.is_reg = 1'b1;
        r.index  = idx;
        r.value  = val;
        r.beat   = '0;
        r.typed  = 1'b0;
        r.want   = '0;
        script.push_back(r);
    endfunction

    function automatic void script_char(input logic [20:0] code, input logic [63:0] bits,
                                        input logic present, input bit typed,
                                        input out_beat_t want);
        script_row_t r;
        r.is_reg = 1'b0;
        r.index  = '0;
        r.value  = '0;
        r.beat   = make_char(code, bits, present);
        r.typed  = typed;
        r.want   = want;
        script.push_back(r);
    endfunction

    function automatic in_beat_t random_char();
        in_beat_t    b;
        int unsigned pick;
        logic [31:0] r;
        logic [31:0] printable;
        pick            = $urandom_range(0, 99);
        r               = $urandom;
        printable       = $urandom_range(32, 126);
        b.glyph_bits    = {$urandom, $urandom};
        b.glyph_present = 1'b1;
        b.char_code     = printable[20:0];
        if (pick < 8)
            b.char_code = CODE_NEWLINE;
        else if (pick < 13)
            b.char_code = CODE_RETURN;
        else if (pick < 20)
            b.char_code = CODE_TAB;
        else if (pick < 28)
        begin
            b.char_code     = CODE_BACKSPACE;
            b.glyph_present = (r[1:0] != 2'b00);
        end
        else if (pick < 36)
            b.glyph_present = 1'b0;
        else if (pick < 48)
        begin
            b.char_code     = r[20:0];
            b.glyph_present = r[21];
        end
        return b;
    endfunction

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (want !== got)
        begin
            $error("%s mismatch: expected 0x%08h, got 0x%08h", name, want, got);
            mismatches++;
        end
    endfunction

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
        @(negedge clk);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        apply_reg(idx, val);
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    task automatic wait_idle();
        @(negedge clk);
        in_valid = 1'b0;
        while (pending_pixels.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic send_char(input in_beat_t beat, input bit typed, input out_beat_t want);
        bit taken;
        @(negedge clk);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid = 1'b1;
        in_data  = beat;
        taken    = 1'b0;
        while (!taken)
        begin
            @(posedge clk);
            if (in_ready)
                taken = 1'b1;
            else
                @(negedge clk);
        end
        predict_glyph_writes(beat);
        if (typed)
            pending_pixels.push_back(want);
        else
            foreach (char_writes[k])
                pending_pixels.push_back(char_writes[k]);
        chars_sent++;
    endtask

    task automatic random_setup(input int unsigned phase);
        logic [31:0] pitch;
        logic [31:0] gw;
        logic [31:0] gh;
        logic [31:0] cols;
        logic [31:0] rows;
        if (phase == 0)
        begin
            pitch = 8;
            gw    = 1;
            gh    = 1;
            cols  = 4;
            rows  = 1;
        end
        else if (phase == RAND_PHASES - 1)
        begin
            pitch = 4096;
            gw    = 8;
            gh    = 8;
            cols  = 512;
            rows  = 512;
        end
        else
        begin
            pitch = $urandom_range(8, 4096);
            gw    = $urandom_range(0, 10);
            gh    = $urandom_range(0, 10);
            cols  = $urandom_range(0, 1) ? $urandom_range(0, 12) : $urandom_range(0, 1023);
            rows  = $urandom_range(0, 1) ? $urandom_range(0, 4) : $urandom_range(0, 1023);
        end
        wait_idle();
        write_reg(REG_FB_BASE, $urandom);
        write_reg(REG_PITCH, pitch);
        write_reg(REG_GLYPH_W, gw);
        write_reg(REG_GLYPH_H, gh);
        write_reg(REG_COLUMNS, cols);
        write_reg(REG_ROWS, rows);
        write_reg(REG_FORE, $urandom);
        write_reg(REG_BACK, $urandom);
        settings_used++;
    endtask

    // receiver: random stalls plus requested long hold-offs
    initial
    begin
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (holds_done != hold_requests)
            begin
                holds_done++;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                out_ready = 1'b0;
                hold_left--;
            end
            else
                out_ready = ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    always @(posedge clk)
    begin : pixel_check
        out_beat_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_pixels.size() == 0)
            begin
                $error("pixel beat with no expectation: addr 0x%08h", out_data.pixel_address);
                mismatches++;
            end
            else
            begin
                want = pending_pixels.pop_front();
                check_field("write_enable", 32'(want.write_enable), 32'(out_data.write_enable));
                check_field("pixel_address", want.pixel_address, out_data.pixel_address);
                check_field("pixel_value", want.pixel_value, out_data.pixel_value);
                check_field("scroll_after", 32'(want.scroll_after), 32'(out_data.scroll_after));
                check_field("last_result", 32'(want.last_result), 32'(out_data.last_result));
                beats_checked++;
            end
        end
    end

    initial
    begin
        #5_000_000;
        $display("simulation failed");
        $finish;
    end

    initial
    begin
        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        in_valid  = 1'b0;
        in_data   = '0;
        r_base    = 32'd0;
        r_pitch   = 13'd640;
        r_gw      = 4'd8;
        r_gh      = 4'd8;
        r_cols    = 10'd80;
        r_rows    = 10'd60;
        r_fore    = 32'd0;
        r_back    = 32'h00FF_FFFF;
        cur_row   = '0;
        cur_col   = '0;

        // reset defaults: control codes, missing glyphs, full 8x8 cells
        script_char(CODE_NEWLINE, 64'd0, 1'b0, 1'b1, NO_PIXEL);
        script_char(CODE_RETURN, 64'd0, 1'b0, 1'b1, NO_PIXEL);
        script_char(CODE_BACKSPACE, 64'd0, 1'b1, 1'b1, NO_PIXEL);
        script_char(21'h41, 64'h0042_427E_4242_2418, 1'b0, 1'b1, NO_PIXEL);
        script_char(21'h41, 64'h0042_427E_4242_2418, 1'b1, 1'b0, NO_PIXEL);
        script_char(21'h10FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 1'b0, NO_PIXEL);
        script_char(CODE_BACKSPACE, 64'd0, 1'b1, 1'b0, NO_PIXEL);
        script_char(CODE_BACKSPACE, 64'd0, 1'b0, 1'b1, NO_PIXEL);
        script_char(CODE_TAB, 64'd0, 1'b0, 1'b0, NO_PIXEL);
        // single-row grid, address wrap, inverted colors
        script_reg(REG_FB_BASE, 32'hFFFF_FFF0);
        script_reg(REG_PITCH, 32'd8);
        script_reg(REG_GLYPH_W, 32'd2);
        script_reg(REG_GLYPH_H, 32'd3);
        script_reg(REG_COLUMNS, 32'd4);
        script_reg(REG_ROWS, 32'd1);
        script_reg(REG_FORE, 32'hFFFF_FFFF);
        script_reg(REG_BACK, 32'd0);
        script_char(21'h1FFFFF, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 1'b0, NO_PIXEL);
        script_char(21'h0, 64'hAA55_AA55_AA55_AA55, 1'b1, 1'b0, NO_PIXEL);
        script_char(CODE_NEWLINE, 64'd0, 1'b0, 1'b1, NO_PIXEL_SCROLL);
        script_char(CODE_TAB, 64'd0, 1'b0, 1'b0, NO_PIXEL);
        // zero-width cell
        script_reg(REG_GLYPH_W, 32'd0);
        script_char(21'h5A, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 1'b0, NO_PIXEL);
        // oversized cell, zero counts
        script_reg(REG_GLYPH_W, 32'd15);
        script_reg(REG_GLYPH_H, 32'd15);
        script_reg(REG_COLUMNS, 32'd0);
        script_reg(REG_ROWS, 32'd0);
        script_char(21'h57, 64'h0123_4567_89AB_CDEF, 1'b1, 1'b0, NO_PIXEL);
        // counts above the maximum, pitch of 4096
        script_reg(REG_GLYPH_W, 32'd8);
        script_reg(REG_GLYPH_H, 32'd8);
        script_reg(REG_COLUMNS, 32'd1023);
        script_reg(REG_ROWS, 32'd1023);
        script_reg(REG_PITCH, 32'd4096);
        script_reg(REG_FB_BASE, 32'd0);
        script_char(CODE_RETURN, 64'd0, 1'b0, 1'b1, NO_PIXEL);
        script_char(21'h78, 64'd0, 1'b1, 1'b0, NO_PIXEL);
        script_char(CODE_NEWLINE, 64'd0, 1'b0, 1'b0, NO_PIXEL);
        script_char(21'h1FFFFF, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 1'b1, NO_PIXEL);

        send_idle_pct = 28;
        recv_idle_pct = 85;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (script[k])
        begin
            if (script[k].is_reg)
            begin
                wait_idle();
                write_reg(script[k].index, script[k].value);
            end
            else
                send_char(script[k].beat, script[k].typed, script[k].want);
        end
        settings_used += 4;

        for (int unsigned phase = 0; phase < RAND_PHASES; phase++)
        begin
            if (phase == 2)
            begin
                send_idle_pct = 85;
                recv_idle_pct = 28;
            end
            else if (phase == 4)
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            random_setup(phase);
            // stall the pixel side while characters keep coming
            if (phase == 4)
                hold_requests++;
            repeat (PHASE_CHARS) send_char(random_char(), 1'b0, NO_PIXEL);
        end

        wait_idle();
        repeat (20) @(posedge clk);
        leftover = pending_pixels.size();
        if (leftover != 0)
        begin
            $error("%0d expected pixel beats never arrived", leftover);
        end

        $display("covered %0d characters over %0d register settings", chars_sent, settings_used);
        $display("checked %0d pixel beats, %0d mismatches", beats_checked, mismatches);
        if (mismatches == 0 && leftover == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
